// File: design/histogram_equalization_unit_macros.svh
// assertion macros used by the checker file
`ifndef HISTOGRAM_EQUALIZATION_UNIT_MACROS_SVH
`define HISTOGRAM_EQUALIZATION_UNIT_MACROS_SVH

// condition then consequence in the same cycle
`define HEQU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition then consequence in the next cycle
`define HEQU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition then consequence at a later cycle
`define HEQU_ASSERT_AFTER2(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> ##1 (cons)) \
		else $error(msg);

`endif

// File: design/hequ_pkg.sv
// shared constants and types of the histogram equalization unit
package hequ_pkg;

	localparam int DEF_BINS       = 256;
	localparam int DEF_CHANNELS   = 3;
	localparam int DEF_COUNT_BITS = 21;

	localparam int PIX_W   = 8;
	localparam int CH_W    = 2;
	localparam int TDATA_W = 16;

	localparam logic [PIX_W-1:0] MAX_RESET = 8'hFF;

	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_MAP   = 1'b1;

	typedef struct packed {
		logic             done;
		logic [PIX_W-1:0] quot;
	} div_stat_t;

endpackage

// File: design/hequ_div.sv
// radix-2 divider giving an 8-bit quotient, all ones on overflow
module hequ_div #(
	parameter int COUNT_BITS = hequ_pkg::DEF_COUNT_BITS,
	parameter int NUM_W      = hequ_pkg::DEF_COUNT_BITS + 2 * hequ_pkg::PIX_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [NUM_W-1:0]      num,
	input  logic [COUNT_BITS-1:0] den,
	output hequ_pkg::div_stat_t   stat
);
	import hequ_pkg::*;

	localparam int HI_W   = NUM_W - PIX_W;
	localparam int STEP_W = $clog2(PIX_W);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [PIX_W-1:0]      lo_q;
	logic [PIX_W-1:0]      quot_q;

	logic [HI_W-1:0]       num_hi;
	logic                  ovf;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	assign num_hi = num[NUM_W-1:PIX_W];
	assign ovf    = num_hi >= HI_W'(den);
	assign trial  = {rem_q, lo_q[PIX_W-1]};
	assign diff   = trial - {1'b0, den};
	assign fits   = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= '0;
				if (ovf) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(PIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= {PIX_W{1'b1}};
			rem_q  <= num_hi[COUNT_BITS-1:0];
			lo_q   <= num[PIX_W-1:0];
		end else if (busy_q) begin
			rem_q  <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			lo_q   <= {lo_q[PIX_W-2:0], 1'b0};
			quot_q <= {quot_q[PIX_W-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign stat.quot = quot_q;

endmodule

// File: design/hequ_map.sv
// mapping table memory with the result register stage
module hequ_map #(
	parameter int CHANNELS = hequ_pkg::DEF_CHANNELS,
	parameter int BINS     = hequ_pkg::DEF_BINS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [$clog2(CHANNELS*BINS)-1:0]     wr_addr,
	input  logic [hequ_pkg::PIX_W-1:0]           wr_data,
	input  logic                                 rd_en,
	input  logic [$clog2(CHANNELS*BINS)-1:0]     rd_addr,
	input  logic [hequ_pkg::CH_W-1:0]            rd_ch,
	output logic                                 busy,
	output logic                                 out_tvalid,
	input  logic                                 out_tready,
	output logic [hequ_pkg::PIX_W-1:0]           out_pixel,
	output logic [hequ_pkg::CH_W-1:0]            out_ch
);
	import hequ_pkg::*;

	localparam int DEPTH = CHANNELS * BINS;

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rd_data_s1;
	logic [CH_W-1:0]  ch_s1;
	logic             pend_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic [CH_W-1:0]  out_ch_q;
	logic             take;

	assign take = pend_q && (!out_valid_q || out_tready);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			ch_s1      <= rd_ch;
		end
		if (take) begin
			out_pixel_q <= rd_data_s1;
			out_ch_q    <= ch_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				pend_q <= 1'b1;
			end else if (take) begin
				pend_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign busy       = pend_q;
	assign out_tvalid = out_valid_q;
	assign out_pixel  = out_pixel_q;
	assign out_ch     = out_ch_q;

endmodule

// File: design/histogram_equalization_unit.sv
// top level of the two-pass per-channel histogram equalization unit
//
// channel  direction  tdata (low bit up)                    tuser  tlast
// s_axis   in         channel[1:0], pixel[9:2]              mode   last
// m_axis   out        mapped_pixel[7:0], out_channel[9:8]   -      -
// cfg      in         pixel ceiling on cfg_wr_data, write on cfg_wr_en
//
// count-pass pixel: bin read then write back (a bad channel is dropped with no bin access)
// map-pass pixel: table read then result register (a bad channel gives no result)
// table build after last: per entry a bin read, running sum, product and divide, the divide
// ending early when the quotient overflows or the total is zero, no input taken meanwhile
// after reset a pass over all CHANNELS*BINS bins zeroes the bin memory
// one result is held and one more is in flight while m_axis stalls
module histogram_equalization_unit #(
	parameter int BINS       = hequ_pkg::DEF_BINS,
	parameter int CHANNELS   = hequ_pkg::DEF_CHANNELS,
	parameter int COUNT_BITS = hequ_pkg::DEF_COUNT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [hequ_pkg::PIX_W-1:0]     cfg_wr_data,   // pixel ceiling
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [hequ_pkg::TDATA_W-1:0]   s_axis_tdata,  // channel, pixel
	input  logic                           s_axis_tuser,  // mode
	input  logic                           s_axis_tlast,  // last
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [hequ_pkg::TDATA_W-1:0]   m_axis_tdata   // mapped_pixel, out_channel
);
	import hequ_pkg::*;

	localparam int DEPTH  = CHANNELS * BINS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int BIN_W  = $clog2(BINS);
	localparam int CUM_W  = COUNT_BITS + BIN_W;
	localparam int PROD_W = CUM_W + PIX_W;
	localparam int CW     = (BIN_W > PIX_W) ? BIN_W : PIX_W;

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_INC,
		S_BRD,
		S_BACC,
		S_BMUL,
		S_BDIV
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BIN_W-1:0]      bin_q;
	logic [CH_W-1:0]       ch_q;
	logic                  last_q;
	logic                  div_go_q;
	logic [PIX_W-1:0]      max_q;
	logic [COUNT_BITS-1:0] totals_q [CHANNELS];
	logic [CUM_W-1:0]      cum_q;
	logic [PROD_W-1:0]     prod_q;
	logic [COUNT_BITS-1:0] tot_q;

	logic [COUNT_BITS-1:0] bin_mem [DEPTH];
	logic [COUNT_BITS-1:0] bin_rd_q;

	logic                  in_acc;
	logic                  in_mode;
	logic [CH_W-1:0]       in_ch;
	logic [PIX_W-1:0]      in_pix;
	logic                  ch_ok;
	logic [PIX_W-1:0]      pix_max;
	logic [CW-1:0]         pix_w;
	logic [CW-1:0]         pix_c;
	logic [ADDR_W-1:0]     in_addr;

	logic                  bin_re;
	logic [ADDR_W-1:0]     bin_raddr;
	logic                  bin_we;
	logic [COUNT_BITS-1:0] bin_wdata;
	logic                  map_re;
	logic                  map_we;
	logic [PIX_W-1:0]      map_wdata;
	logic                  map_busy;
	logic [COUNT_BITS-1:0] tot_rd;
	logic [COUNT_BITS-1:0] tot_inc;
	logic [PROD_W-1:0]     prod_d;
	logic [PIX_W-1:0]      out_pixel;
	logic [CH_W-1:0]       out_ch;
	div_stat_t             div_stat;

	// input fields and bin address
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign in_mode = s_axis_tuser;
	assign in_ch   = s_axis_tdata[CH_W-1:0];
	assign in_pix  = s_axis_tdata[CH_W+PIX_W-1:CH_W];
	assign ch_ok   = {1'b0, in_ch} < (CH_W + 1)'(CHANNELS);
	assign pix_max = (in_pix > max_q) ? max_q : in_pix;
	assign pix_w   = CW'(pix_max);
	assign pix_c   = (pix_w > CW'(BINS - 1)) ? CW'(BINS - 1) : pix_w;
	assign in_addr = ADDR_W'(in_ch) * ADDR_W'(BINS) + ADDR_W'(pix_c[BIN_W-1:0]);

	assign s_axis_tready = (state_q == S_IDLE) && !map_busy;

	always_comb begin
		tot_rd = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch_q == CH_W'(i)) begin
				tot_rd = totals_q[i];
			end
		end
	end

	assign tot_inc   = (&tot_rd) ? tot_rd : tot_rd + 1'b1;
	assign prod_d    = PROD_W'(max_q) * PROD_W'(cum_q);
	assign map_we    = (state_q == S_BDIV) && div_stat.done;
	assign map_wdata = (tot_q == '0) ? '0 :
		((div_stat.quot > max_q) ? max_q : div_stat.quot);

	always_comb begin
		bin_re    = 1'b0;
		bin_raddr = addr_q;
		bin_we    = 1'b0;
		bin_wdata = '0;
		map_re    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				bin_we = 1'b1;
			end
			S_IDLE: begin
				if (in_acc && ch_ok && in_mode == MODE_COUNT) begin
					bin_re    = 1'b1;
					bin_raddr = in_addr;
				end
				map_re = in_acc && ch_ok && in_mode == MODE_MAP;
			end
			S_INC: begin
				bin_we    = 1'b1;
				bin_wdata = (&bin_rd_q) ? bin_rd_q : bin_rd_q + 1'b1;
			end
			S_BRD: begin
				bin_re = 1'b1;
			end
			S_BACC: begin
				bin_we = 1'b1;
			end
			S_BMUL, S_BDIV: begin
			end
		endcase
	end

	// bin memory
	always_ff @(posedge clk) begin
		if (bin_we) begin
			bin_mem[addr_q] <= bin_wdata;
		end
		if (bin_re) begin
			bin_rd_q <= bin_mem[bin_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			addr_q   <= '0;
			bin_q    <= '0;
			ch_q     <= '0;
			last_q   <= 1'b0;
			div_go_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				totals_q[i] <= '0;
			end
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == ADDR_W'(DEPTH - 1)) begin
						addr_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && in_mode == MODE_COUNT) begin
						if (ch_ok) begin
							addr_q  <= in_addr;
							ch_q    <= in_ch;
							last_q  <= s_axis_tlast;
							state_q <= S_INC;
						end else if (s_axis_tlast) begin
							addr_q  <= '0;
							bin_q   <= '0;
							ch_q    <= '0;
							state_q <= S_BRD;
						end
					end
				end
				S_INC: begin
					for (int i = 0; i < CHANNELS; i++) begin
						if (ch_q == CH_W'(i)) begin
							totals_q[i] <= tot_inc;
						end
					end
					if (last_q) begin
						addr_q  <= '0;
						bin_q   <= '0;
						ch_q    <= '0;
						state_q <= S_BRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BRD: begin
					state_q <= S_BACC;
				end
				S_BACC: begin
					state_q <= S_BMUL;
				end
				S_BMUL: begin
					div_go_q <= 1'b1;
					state_q  <= S_BDIV;
				end
				S_BDIV: begin
					if (div_stat.done) begin
						if (addr_q == ADDR_W'(DEPTH - 1)) begin
							for (int i = 0; i < CHANNELS; i++) begin
								totals_q[i] <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							addr_q <= addr_q + 1'b1;
							if (bin_q == BIN_W'(BINS - 1)) begin
								bin_q <= '0;
								ch_q  <= ch_q + 1'b1;
							end else begin
								bin_q <= bin_q + 1'b1;
							end
							state_q <= S_BRD;
						end
					end
				end
			endcase
		end
	end

	// build datapath: running sum and product
	always_ff @(posedge clk) begin
		if (state_q == S_BRD) begin
			tot_q <= tot_rd;
		end
		if (state_q == S_BACC) begin
			cum_q <= ((bin_q == '0) ? '0 : cum_q) + CUM_W'(bin_rd_q);
		end
		if (state_q == S_BMUL) begin
			prod_q <= prod_d;
		end
	end

	hequ_div #(
		.COUNT_BITS (COUNT_BITS),
		.NUM_W      (PROD_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (prod_q),
		.den    (tot_q),
		.stat   (div_stat)
	);

	hequ_map #(
		.CHANNELS (CHANNELS),
		.BINS     (BINS)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (map_we),
		.wr_addr    (addr_q),
		.wr_data    (map_wdata),
		.rd_en      (map_re),
		.rd_addr    (in_addr),
		.rd_ch      (in_ch),
		.busy       (map_busy),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_pixel  (out_pixel),
		.out_ch     (out_ch)
	);

	assign m_axis_tdata = {(TDATA_W - PIX_W - CH_W)'(0), out_ch, out_pixel};

endmodule

// File: design/hequ_checker.sv
// port-level assertions of the histogram equalization unit and their bind
`include "histogram_equalization_unit_macros.svh"

module hequ_checker #(
	parameter int CHANNELS = hequ_pkg::DEF_CHANNELS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [hequ_pkg::TDATA_W-1:0] s_axis_tdata,
	input logic                         s_axis_tuser,
	input logic                         s_axis_tlast,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [hequ_pkg::TDATA_W-1:0] m_axis_tdata
);
	import hequ_pkg::*;

	logic s_acc;
	logic s_ch_ok;
	logic s_cnt;
	logic s_map;
	logic m_stall;

	assign s_acc   = s_axis_tvalid && s_axis_tready;
	assign s_ch_ok = {1'b0, s_axis_tdata[CH_W-1:0]} < (CH_W + 1)'(CHANNELS);
	assign s_cnt   = s_acc && s_axis_tuser == MODE_COUNT;
	assign s_map   = s_acc && s_axis_tuser == MODE_MAP;
	assign m_stall = m_axis_tvalid && !m_axis_tready;

	`HEQU_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid, "result dropped while stalled")

	`HEQU_ASSERT_NEXT(a_out_stable, m_stall, $stable(m_axis_tdata), "stalled result changed")

	`HEQU_ASSERT_NOW(a_count_busy, s_cnt && s_ch_ok, 1'b1, "count transaction seen")

	`HEQU_ASSERT_NEXT(a_count_hold, s_cnt && s_ch_ok, !s_axis_tready, "no bin update after count")

	`HEQU_ASSERT_AFTER2(a_build_busy, s_cnt && s_axis_tlast, !s_axis_tready, "input during build")

	`HEQU_ASSERT_AFTER2(a_map_lands, s_map && s_ch_ok && !m_stall, m_axis_tvalid, "map result missing")

endmodule

bind histogram_equalization_unit hequ_checker #(
	.CHANNELS (CHANNELS)
) u_hequ_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
